### hw/rtl/binned_max_quality_store_defines.svh
// Assertion macros for the binned maximum quality store
`ifndef BINNED_MAX_QUALITY_STORE_DEFINES_SVH
`define BINNED_MAX_QUALITY_STORE_DEFINES_SVH

// same-cycle implication, clocked on clk, off during reset
`define BMQS_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, clocked on clk, off during reset
`define BMQS_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### hw/rtl/bmqs_pkg.sv
// Shared constants, types and command/status structs for the binned maximum quality store
package bmqs_pkg;

	localparam int NUM_BINS    = 65536;
	localparam int ADDR_W      = $clog2(NUM_BINS);
	localparam int BIN_W       = 32;
	localparam int START_W     = 31;
	localparam int LEN_W       = 20;
	localparam int QUAL_W      = 8;
	localparam int IDX_W       = 16;
	localparam int BS_W        = 21;
	localparam int BSTART_W    = 36;
	localparam int DIV_CNT_W   = $clog2(START_W + 1);
	localparam int PADDR_W     = 3;
	localparam int PDATA_W     = 32;

	localparam logic [BS_W-1:0]   BIN_SIZE_RESET = BS_W'(100);
	localparam logic [QUAL_W-1:0] QUAL_MAX       = '1;

	// register index, taken from paddr[PADDR_W-1]
	localparam logic CFG_BIN_SIZE = 1'b0;

	typedef enum logic [6:0] {
		S_CLEAR = 7'b0000001,
		S_IDLE  = 7'b0000010,
		S_DIV   = 7'b0000100,
		S_WRD   = 7'b0001000,
		S_WWR   = 7'b0010000,
		S_RD    = 7'b0100000,
		S_FIN   = 7'b1000000
	} state_t;

	typedef struct packed {
		logic load;
		logic div_start;
		logic bin_load;
		logic mem_re;
		logic walk_we;
		logic clr_we;
		logic set_oor;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		logic div_busy;
		logic rem_zero;
		logic bin_oob;
		logic clr_last;
	} sts_t;

endpackage

### hw/rtl/bmqs_if.sv
// Valid/ready channel interfaces for input transactions and result transactions
interface bmqs_in_if;
	logic                             valid;
	logic                             ready;
	logic                             mode;
	logic [bmqs_pkg::START_W-1:0]     start_position;
	logic [bmqs_pkg::LEN_W-1:0]       read_length;
	logic [bmqs_pkg::QUAL_W-1:0]      map_quality;
	logic [bmqs_pkg::IDX_W-1:0]       bin_index;

	modport source (output valid, mode, start_position, read_length, map_quality, bin_index,
		input ready);
	modport sink (input valid, mode, start_position, read_length, map_quality, bin_index,
		output ready);
endinterface

interface bmqs_out_if;
	logic                             valid;
	logic                             ready;
	logic [bmqs_pkg::QUAL_W-1:0]      bin_value;
	logic [bmqs_pkg::BSTART_W-1:0]    bin_start;
	logic                             out_of_range;

	modport source (output valid, bin_value, bin_start, out_of_range, input ready);
	modport sink (input valid, bin_value, bin_start, out_of_range, output ready);
endinterface

### hw/rtl/bmqs_div.sv
// Restoring divider, one quotient bit per cycle, for the first bin of a read
module bmqs_div (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [bmqs_pkg::START_W-1:0]  dividend,
	input  logic [bmqs_pkg::BS_W-1:0]     divisor,
	output logic                          busy,
	output logic [bmqs_pkg::START_W-1:0]  quotient
);

	logic [bmqs_pkg::DIV_CNT_W-1:0] cnt_q;
	logic [bmqs_pkg::START_W-1:0]   quo_q;
	logic [bmqs_pkg::BS_W-1:0]      rem_q;
	logic [bmqs_pkg::BS_W:0]        shifted;
	logic [bmqs_pkg::BS_W:0]        diff;

	assign shifted  = {rem_q, quo_q[bmqs_pkg::START_W-1]};
	assign diff     = shifted - {1'b0, divisor};
	assign busy     = (cnt_q != '0);
	assign quotient = quo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= bmqs_pkg::DIV_CNT_W'(bmqs_pkg::START_W);
		end else if (busy) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
		end else if (busy) begin
			if (!diff[bmqs_pkg::BS_W]) begin
				rem_q <= diff[bmqs_pkg::BS_W-1:0];
				quo_q <= {quo_q[bmqs_pkg::START_W-2:0], 1'b1};
			end else begin
				rem_q <= shifted[bmqs_pkg::BS_W-1:0];
				quo_q <= {quo_q[bmqs_pkg::START_W-2:0], 1'b0};
			end
		end
	end

endmodule

### hw/rtl/bmqs_dp.sv
// Datapath: bin table memory, bin walk registers, bin start product and result register
module bmqs_dp (
	input  logic                           clk,
	input  logic                           arst_n,
	input  bmqs_pkg::cmd_t                 cmd,
	output bmqs_pkg::sts_t                 sts,
	input  logic [bmqs_pkg::BS_W-1:0]      bin_size,
	input  logic                           in_mode,
	input  logic [bmqs_pkg::START_W-1:0]   in_start_position,
	input  logic [bmqs_pkg::LEN_W-1:0]     in_read_length,
	input  logic [bmqs_pkg::QUAL_W-1:0]    in_map_quality,
	input  logic [bmqs_pkg::IDX_W-1:0]     in_bin_index,
	output logic [bmqs_pkg::QUAL_W-1:0]    bin_value,
	output logic [bmqs_pkg::BSTART_W-1:0]  bin_start,
	output logic                           out_of_range
);

	logic [bmqs_pkg::QUAL_W-1:0]   mem [bmqs_pkg::NUM_BINS];
	logic [bmqs_pkg::QUAL_W-1:0]   rdata_q;
	logic [bmqs_pkg::ADDR_W-1:0]   clr_cnt_q;
	logic                          mode_q;
	logic [bmqs_pkg::QUAL_W-1:0]   qv_q;
	logic [bmqs_pkg::LEN_W-1:0]    rem_q;
	logic [bmqs_pkg::IDX_W-1:0]    idx_q;
	logic [bmqs_pkg::BIN_W-1:0]    bin_q;
	logic                          oor_q;
	logic [bmqs_pkg::BSTART_W-1:0] mul_q;
	logic [bmqs_pkg::QUAL_W-1:0]   bin_value_q;
	logic [bmqs_pkg::BSTART_W-1:0] bin_start_q;
	logic                          out_of_range_q;

	logic [bmqs_pkg::START_W-1:0]        quotient;
	logic [bmqs_pkg::IDX_W+bmqs_pkg::BS_W-1:0] mul_full;
	logic                                idx_in_range;
	logic [bmqs_pkg::ADDR_W-1:0]         raddr;
	logic [bmqs_pkg::ADDR_W-1:0]         waddr;
	logic [bmqs_pkg::QUAL_W-1:0]         wdata;
	logic                                we;
	logic [bmqs_pkg::QUAL_W-1:0]         raised;

	bmqs_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (in_start_position),
		.divisor  (bin_size),
		.busy     (sts.div_busy),
		.quotient (quotient)
	);

	assign sts.rem_zero = (rem_q == '0);
	assign sts.bin_oob  = (bin_q >= bmqs_pkg::BIN_W'(bmqs_pkg::NUM_BINS));
	assign sts.clr_last = (clr_cnt_q == bmqs_pkg::ADDR_W'(bmqs_pkg::NUM_BINS - 1));

	assign idx_in_range = (bmqs_pkg::BIN_W'(idx_q) < bmqs_pkg::BIN_W'(bmqs_pkg::NUM_BINS));
	assign mul_full = {{bmqs_pkg::BS_W{1'b0}}, idx_q} * {{bmqs_pkg::IDX_W{1'b0}}, bin_size};
	assign raddr    = mode_q ? bmqs_pkg::ADDR_W'(idx_q) : bin_q[bmqs_pkg::ADDR_W-1:0];
	assign raised   = (qv_q > rdata_q) ? qv_q : rdata_q;
	assign we       = cmd.clr_we | cmd.walk_we;
	assign waddr    = cmd.clr_we ? clr_cnt_q : bin_q[bmqs_pkg::ADDR_W-1:0];
	assign wdata    = cmd.clr_we ? '0 : raised;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (cmd.mem_re) begin
			rdata_q <= mem[raddr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_cnt_q <= '0;
		end else if (cmd.clr_we) begin
			clr_cnt_q <= clr_cnt_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		mul_q <= mul_full[bmqs_pkg::BSTART_W-1:0];
		if (cmd.load) begin
			mode_q <= in_mode;
			qv_q   <= (in_map_quality == bmqs_pkg::QUAL_MAX) ? bmqs_pkg::QUAL_MAX
				: in_map_quality + 1'b1;
			rem_q  <= in_read_length;
			idx_q  <= in_bin_index;
			oor_q  <= 1'b0;
		end else begin
			if (cmd.set_oor) begin
				oor_q <= 1'b1;
			end
			if (cmd.walk_we) begin
				if ({1'b0, rem_q} <= bmqs_pkg::BS_W'(bin_size)) begin
					rem_q <= '0;
				end else begin
					rem_q <= rem_q - bin_size[bmqs_pkg::LEN_W-1:0];
				end
			end
		end
		if (cmd.bin_load) begin
			bin_q <= bmqs_pkg::BIN_W'(quotient);
		end else if (cmd.walk_we) begin
			bin_q <= bin_q + 1'b1;
		end
		if (cmd.out_load) begin
			if (mode_q) begin
				bin_value_q    <= idx_in_range ? rdata_q : '0;
				bin_start_q    <= mul_q;
				out_of_range_q <= !idx_in_range;
			end else begin
				bin_value_q    <= '0;
				bin_start_q    <= '0;
				out_of_range_q <= oor_q;
			end
		end
	end

	assign bin_value    = bin_value_q;
	assign bin_start    = bin_start_q;
	assign out_of_range = out_of_range_q;

endmodule

### hw/rtl/bmqs_ctrl.sv
// Controller: table clear after reset, divide, bin walk, bin read and result hand-off
`include "binned_max_quality_store_defines.svh"

module bmqs_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	input  logic           in_mode,
	output logic           in_ready,
	output logic           out_valid,
	input  logic           out_ready,
	output bmqs_pkg::cmd_t cmd,
	input  bmqs_pkg::sts_t sts
);

	bmqs_pkg::state_t state_q;
	bmqs_pkg::state_t state_d;
	logic             out_valid_q;
	logic             slot_free;

	assign slot_free = !out_valid_q || out_ready;
	assign in_ready  = (state_q == bmqs_pkg::S_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			bmqs_pkg::S_CLEAR: begin
				cmd.clr_we = 1'b1;
				if (sts.clr_last) begin
					state_d = bmqs_pkg::S_IDLE;
				end
			end
			bmqs_pkg::S_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					if (in_mode) begin
						state_d = bmqs_pkg::S_RD;
					end else begin
						cmd.div_start = 1'b1;
						state_d       = bmqs_pkg::S_DIV;
					end
				end
			end
			bmqs_pkg::S_DIV: begin
				if (!sts.div_busy) begin
					cmd.bin_load = 1'b1;
					state_d      = bmqs_pkg::S_WRD;
				end
			end
			bmqs_pkg::S_WRD: begin
				if (sts.rem_zero) begin
					state_d = bmqs_pkg::S_FIN;
				end else if (sts.bin_oob) begin
					cmd.set_oor = 1'b1;
					state_d     = bmqs_pkg::S_FIN;
				end else begin
					cmd.mem_re = 1'b1;
					state_d    = bmqs_pkg::S_WWR;
				end
			end
			bmqs_pkg::S_WWR: begin
				cmd.walk_we = 1'b1;
				state_d     = bmqs_pkg::S_WRD;
			end
			bmqs_pkg::S_RD: begin
				cmd.mem_re = 1'b1;
				state_d    = bmqs_pkg::S_FIN;
			end
			bmqs_pkg::S_FIN: begin
				if (slot_free) begin
					cmd.out_load = 1'b1;
					state_d      = bmqs_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = bmqs_pkg::S_CLEAR;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= bmqs_pkg::S_CLEAR;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	`BMQS_ASSERT_IMP(a_div_in_div_state, sts.div_busy, state_q == bmqs_pkg::S_DIV,
		"divider busy outside the divide state")
	`BMQS_ASSERT_IMP(a_out_load_free, cmd.out_load, !out_valid_q || out_ready,
		"result register overwritten while still held")
	`BMQS_ASSERT_NXT(a_accept_leaves_idle, in_valid && in_ready, state_q != bmqs_pkg::S_IDLE,
		"accepted transaction did not start work")

endmodule

### hw/rtl/binned_max_quality_store.sv
// Read mode: the entry is read and the result registered; no new input is accepted until
// the result is loaded. Record mode: the divide state finds the first bin, then each
// visited bin takes a read state and a write state (read-modify-write on the table).
// Once arst_n is released the table is cleared, one entry a cycle, all 65536 entries with no
// input accepted; bin_size resets to 100 and register writes are taken throughout.
// A result waits in an output register and is held until taken.
module binned_max_quality_store (
	input  logic                           clk,
	input  logic                           arst_n,
	bmqs_in_if.sink                        in_ch,
	bmqs_out_if.source                     out_ch,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [bmqs_pkg::PADDR_W-1:0]   paddr,
	input  logic [bmqs_pkg::PDATA_W-1:0]   pwdata,
	output logic [bmqs_pkg::PDATA_W-1:0]   prdata,
	output logic                           pready
);

	logic [bmqs_pkg::BS_W-1:0] bin_size_q;
	logic [bmqs_pkg::BS_W-1:0] bin_size_eff;
	logic                      sel_bin_size;
	bmqs_pkg::cmd_t            cmd;
	bmqs_pkg::sts_t            sts;

	assign pready       = 1'b1;
	assign sel_bin_size = (paddr[bmqs_pkg::PADDR_W-1] == bmqs_pkg::CFG_BIN_SIZE);
	assign prdata       = sel_bin_size ? bmqs_pkg::PDATA_W'(bin_size_q) : '0;
	assign bin_size_eff = (bin_size_q == '0) ? bmqs_pkg::BS_W'(1) : bin_size_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bin_size_q <= bmqs_pkg::BIN_SIZE_RESET;
		end else if (psel && penable && pwrite && sel_bin_size) begin
			bin_size_q <= pwdata[bmqs_pkg::BS_W-1:0];
		end
	end

	bmqs_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_ch.valid),
		.in_mode   (in_ch.mode),
		.in_ready  (in_ch.ready),
		.out_valid (out_ch.valid),
		.out_ready (out_ch.ready),
		.cmd       (cmd),
		.sts       (sts)
	);

	bmqs_dp u_dp (
		.clk               (clk),
		.arst_n            (arst_n),
		.cmd               (cmd),
		.sts               (sts),
		.bin_size          (bin_size_eff),
		.in_mode           (in_ch.mode),
		.in_start_position (in_ch.start_position),
		.in_read_length    (in_ch.read_length),
		.in_map_quality    (in_ch.map_quality),
		.in_bin_index      (in_ch.bin_index),
		.bin_value         (out_ch.bin_value),
		.bin_start         (out_ch.bin_start),
		.out_of_range      (out_ch.out_of_range)
	);

endmodule
